/* hdl/tsch_pkg.sv */
package tsch_pkg;

    localparam int NOW_W     = 64;
    localparam int TICKS_W   = 8;
    localparam int STEP_W    = 21;
    localparam int ALPHA_W   = 16;
    localparam int CAP_W     = 8;
    localparam int THR_W     = 32;
    localparam int FSEL_W    = 4;
    localparam int SPEED_W   = 10;
    localparam int DELTA_W   = 32;
    localparam int PROD_W    = DELTA_W + SPEED_W;
    localparam int SPEED_SH  = 8;

    localparam logic [SPEED_W-1:0] SPEED_MIN = 10'd256;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 10'd512;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CATCH_UP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSPEND_THR   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FACTOR  = 8'd3;

    localparam logic [CAP_W-1:0]   RST_MAX_CATCH_UP = 8'd1;
    localparam logic [THR_W-1:0]   RST_SUSPEND_THR  = 32'd0;
    localparam logic [FSEL_W-1:0]  RST_FRAME_RATE   = 4'd1;
    localparam logic [SPEED_W-1:0] RST_SPEED_FACTOR = 10'd256;

    typedef enum logic [1:0] {
        DS_TICK  = 2'd0,
        DS_ALPHA = 2'd1,
        DS_DEAD  = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     check;
        logic     mul;
        logic     div_start;
        t_div_sel div_sel;
        logic     store_tick;
        logic     store_alpha;
        logic     store_dead;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic div_done;
    } t_stat;

endpackage

/* hdl/tsch_div.sv */
module tsch_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 21,
    parameter int CNT_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [NUM_W-1:0] i_num,
    input  logic [CNT_W-1:0] i_cnt,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem,
    output logic             o_done
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_trial;
    logic             w_fit;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cnt;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= i_rem;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
            r_rem <= w_fit ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

/* hdl/tsch_dp.sv */
module tsch_dp #(
    parameter int HALF_FRAME_UNITS = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tsch_pkg::t_cmd                   i_cmd,
    output tsch_pkg::t_stat                  o_stat,
    input  logic [tsch_pkg::NOW_W-1:0]       i_now,
    input  logic                             i_cfg_we,
    input  logic [tsch_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tsch_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [tsch_pkg::TICKS_W-1:0]     o_ticks,
    output logic [tsch_pkg::STEP_W-1:0]      o_step_period,
    output logic [tsch_pkg::ALPHA_W-1:0]     o_alpha,
    output logic [tsch_pkg::NOW_W-1:0]       o_next_deadline,
    output logic [tsch_pkg::NOW_W-1:0]       o_discarded_total
);

    import tsch_pkg::*;

    localparam int PERIOD_MAX = 30 * HALF_FRAME_UNITS;
    localparam int PERIOD_W   = $clog2(PERIOD_MAX + 1);
    localparam int TOT_W      = ((PERIOD_W > PROD_W - SPEED_SH - 1) ?
                                 PERIOD_W : (PROD_W - SPEED_SH - 1)) + 1;
    localparam int NUM_W      = TOT_W;
    localparam int DEAD_N     = PERIOD_W + SPEED_SH;
    localparam int DEAD_SH    = NUM_W - DEAD_N;
    localparam int CNT_W      = $clog2(NUM_W + 1);

    logic [CAP_W-1:0]    r_max;
    logic [THR_W-1:0]    r_thresh;
    logic [FSEL_W-1:0]   r_fsel;
    logic [SPEED_W-1:0]  r_speed;
    logic                r_init;
    logic [NOW_W-1:0]    r_last;
    logic [PERIOD_W-1:0] r_acc;
    logic [NOW_W-1:0]    r_discard;

    logic [NOW_W-1:0]    r_now;
    logic [NOW_W-1:0]    r_delta;
    logic                r_reinit;
    logic                r_skip;
    logic [PROD_W-1:0]   r_prod;
    logic [TICKS_W-1:0]  r_ticks;
    logic [ALPHA_W-1:0]  r_alpha;
    logic [NOW_W-1:0]    r_deadline;

    logic [TICKS_W-1:0]  r_out_ticks;
    logic [STEP_W-1:0]   r_out_step;
    logic [ALPHA_W-1:0]  r_out_alpha;
    logic [NOW_W-1:0]    r_out_deadline;
    logic [NOW_W-1:0]    r_out_discard;

    logic [PERIOD_W-1:0] w_period;
    logic [SPEED_W-1:0]  w_speed;
    logic [CAP_W-1:0]    w_cap;
    logic                n_skip;
    logic [TOT_W-1:0]    w_total;
    logic [PERIOD_W-1:0] w_gap;
    logic [TOT_W-1:0]    w_quo_tick;
    logic [TICKS_W-1:0]  w_ticks;

    logic [PERIOD_W-1:0] w_div_rem_in;
    logic [NUM_W-1:0]    w_div_num;
    logic [CNT_W-1:0]    w_div_cnt;
    logic [PERIOD_W-1:0] w_div_den;
    logic [NUM_W-1:0]    w_div_quo;
    logic [PERIOD_W-1:0] w_div_rem;
    logic                w_div_done;

    always_comb begin
        if (r_fsel == '0) begin
            w_period = PERIOD_W'(HALF_FRAME_UNITS);
        end else begin
            w_period = PERIOD_W'(PERIOD_W'(r_fsel) * PERIOD_W'(2 * HALF_FRAME_UNITS));
        end
        if (r_speed < SPEED_MIN) begin
            w_speed = SPEED_MIN;
        end else if (r_speed > SPEED_MAX) begin
            w_speed = SPEED_MAX;
        end else begin
            w_speed = r_speed;
        end
    end

    assign w_cap      = (r_max == '0) ? CAP_W'(1) : r_max;
    assign n_skip     = r_reinit || (r_delta >= NOW_W'(r_thresh));
    assign w_total    = TOT_W'(r_acc) + TOT_W'(r_prod >> SPEED_SH);
    assign w_gap      = w_period - r_acc;
    assign w_quo_tick = w_div_quo[TOT_W-1:0];
    assign w_ticks    = (w_quo_tick >= TOT_W'(w_cap)) ? w_cap : w_quo_tick[TICKS_W-1:0];

    always_comb begin
        w_div_rem_in = '0;
        w_div_num    = '0;
        w_div_cnt    = CNT_W'(NUM_W);
        w_div_den    = w_period;
        case (i_cmd.div_sel)
            DS_TICK: begin
                w_div_num = NUM_W'(w_total);
                w_div_cnt = CNT_W'(NUM_W);
            end
            DS_ALPHA: begin
                w_div_rem_in = w_div_rem;
                w_div_cnt    = CNT_W'(ALPHA_W);
            end
            DS_DEAD: begin
                w_div_num = NUM_W'({w_gap, {SPEED_SH{1'b0}}}) << DEAD_SH;
                w_div_cnt = CNT_W'(DEAD_N);
                w_div_den = PERIOD_W'(w_speed);
            end
            default: begin
                w_div_cnt = CNT_W'(NUM_W);
            end
        endcase
    end

    tsch_div #(
        .NUM_W (NUM_W),
        .DEN_W (PERIOD_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_rem   (w_div_rem_in),
        .i_num   (w_div_num),
        .i_cnt   (w_div_cnt),
        .i_den   (w_div_den),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem),
        .o_done  (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= RST_MAX_CATCH_UP;
            r_thresh  <= RST_SUSPEND_THR;
            r_fsel    <= RST_FRAME_RATE;
            r_speed   <= RST_SPEED_FACTOR;
            r_init    <= 1'b0;
            r_last    <= '0;
            r_acc     <= '0;
            r_discard <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_CATCH_UP: begin
                        r_max  <= i_cfg_data[CAP_W-1:0];
                        r_init <= 1'b0;
                    end
                    CFG_SUSPEND_THR: begin
                        r_thresh <= i_cfg_data[THR_W-1:0];
                        r_init   <= 1'b0;
                    end
                    CFG_FRAME_RATE: begin
                        r_fsel <= i_cfg_data[FSEL_W-1:0];
                        r_init <= 1'b0;
                    end
                    CFG_SPEED_FACTOR: begin
                        r_speed <= i_cfg_data[SPEED_W-1:0];
                        r_init  <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.check) begin
                r_init <= 1'b1;
                r_last <= r_now;
            end
            if (i_cmd.mul && n_skip) begin
                r_acc <= '0;
            end
            if (i_cmd.store_tick) begin
                r_acc     <= w_div_rem;
                r_discard <= r_discard + (NOW_W'(w_quo_tick) - NOW_W'(w_ticks));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= i_now;
        end
        if (i_cmd.check) begin
            r_delta  <= r_now - r_last;
            r_reinit <= !r_init || (r_now < r_last);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_delta[DELTA_W-1:0]) * PROD_W'(w_speed);
            r_skip <= n_skip;
            if (n_skip) begin
                r_ticks <= '0;
                r_alpha <= '0;
            end
        end
        if (i_cmd.store_tick) begin
            r_ticks <= w_ticks;
        end
        if (i_cmd.store_alpha) begin
            r_alpha <= w_div_quo[ALPHA_W-1:0];
        end
        if (i_cmd.store_dead) begin
            r_deadline <= r_now + NOW_W'(w_div_quo[PERIOD_W-1:0]);
        end
        if (i_cmd.load_out) begin
            r_out_ticks    <= r_ticks;
            r_out_step     <= STEP_W'(w_period);
            r_out_alpha    <= r_alpha;
            r_out_deadline <= r_deadline;
            r_out_discard  <= r_discard;
        end
    end

    assign o_stat.skip     = r_skip;
    assign o_stat.div_done = w_div_done;

    assign o_ticks           = r_out_ticks;
    assign o_step_period     = r_out_step;
    assign o_alpha           = r_out_alpha;
    assign o_next_deadline   = r_out_deadline;
    assign o_discarded_total = r_out_discard;

endmodule

/* hdl/tsch_ctrl.sv */
module tsch_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tsch_pkg::t_cmd  o_cmd,
    input  tsch_pkg::t_stat i_stat
);

    import tsch_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_ADD   = 8'b0000_1000,
        S_TICK  = 8'b0001_0000,
        S_ALPHA = 8'b0010_0000,
        S_DEAD  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                w_cmd.check = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                w_cmd.div_start = 1'b1;
                if (i_stat.skip) begin
                    w_cmd.div_sel = DS_DEAD;
                    n_state       = S_DEAD;
                end else begin
                    w_cmd.div_sel = DS_TICK;
                    n_state       = S_TICK;
                end
            end
            S_TICK: begin
                if (i_stat.div_done) begin
                    w_cmd.store_tick = 1'b1;
                    w_cmd.div_start  = 1'b1;
                    w_cmd.div_sel    = DS_ALPHA;
                    n_state          = S_ALPHA;
                end
            end
            S_ALPHA: begin
                if (i_stat.div_done) begin
                    w_cmd.store_alpha = 1'b1;
                    w_cmd.div_start   = 1'b1;
                    w_cmd.div_sel     = DS_DEAD;
                    n_state           = S_DEAD;
                end
            end
            S_DEAD: begin
                if (i_stat.div_done) begin
                    w_cmd.store_dead = 1'b1;
                    n_state          = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CHECK))
        else $error("Accepted item did not start processing.");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_TICK || r_state == S_ALPHA || r_state == S_DEAD))
        else $error("Divider finished outside a divide state.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> (o_out_valid && $past(!r_out_valid || !i_out_stall)))
        else $error("Result loaded over an untaken result.");

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_out_valid) |=> (r_state == S_IDLE))
        else $error("Finished item did not reach the output register.");

endmodule

/* hdl/fixed_step_tick_scheduler_core.sv */
// Fixed-timestep tick scheduler.
// Input channel: i_in_valid / o_in_stall carry one timestamp item on i_now.
// Output channel: o_out_valid / i_out_stall carry one result item per input:
// tick count, step period, interpolation fraction, next deadline and the
// running count of ticks dropped by the catch-up cap.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data.
// Index 0 is the catch-up cap, 1 the suspend threshold, 2 the frame rate
// select and 3 the speed factor; other indexes are ignored.
// A normal item passes through check, multiply and add, then the tick count,
// fraction and deadline divisions, and then the output load.
// A re-initialising or suspended item skips the tick count and fraction divisions.
// The divisions use the shared serial divider, which produces one quotient
// bit per cycle for the tick count, the fraction and the deadline in turn.
// One item is processed at a time; a new item is taken as soon as the previous
// result has moved to the output register, even if it is not yet taken.
// While the receiver stalls, the result is held and the next finished result
// waits in the block. Reset restores the register defaults and clears time.
module fixed_step_tick_scheduler_core #(
    parameter int HALF_FRAME_UNITS = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [tsch_pkg::NOW_W-1:0]       i_now,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [tsch_pkg::TICKS_W-1:0]     o_ticks,
    output logic [tsch_pkg::STEP_W-1:0]      o_step_period,
    output logic [tsch_pkg::ALPHA_W-1:0]     o_alpha,
    output logic [tsch_pkg::NOW_W-1:0]       o_next_deadline,
    output logic [tsch_pkg::NOW_W-1:0]       o_discarded_total,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tsch_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tsch_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import tsch_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    tsch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    tsch_dp #(
        .HALF_FRAME_UNITS (HALF_FRAME_UNITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_now             (i_now),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_ticks           (o_ticks),
        .o_step_period     (o_step_period),
        .o_alpha           (o_alpha),
        .o_next_deadline   (o_next_deadline),
        .o_discarded_total (o_discarded_total)
    );

endmodule

/* verif/fixed_step_tick_scheduler_core_tb.sv */
`timescale 1ns / 1ps

module fixed_step_tick_scheduler_core_tb;

    import tsch_pkg::*;

    localparam int          HALF_FRAME     = 65536;
    localparam int unsigned RANDOM_ITEMS   = 1930;
    localparam int unsigned CYCLE_LIMIT    = 4000000;
    localparam int unsigned END_WAIT       = 200;
    localparam int unsigned PRINT_LIMIT    = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = 8'hFF;

    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        logic [STEP_W-1:0]  period;
        logic [ALPHA_W-1:0] alpha;
        logic [NOW_W-1:0]   deadline;
        logic [NOW_W-1:0]   dropped;
    } t_tick_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [NOW_W-1:0]      i_now = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [TICKS_W-1:0]    o_ticks;
    logic [STEP_W-1:0]     o_step_period;
    logic [ALPHA_W-1:0]    o_alpha;
    logic [NOW_W-1:0]      o_next_deadline;
    logic [NOW_W-1:0]      o_discarded_total;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Local copy of the scheduler registers and timing state.
    logic [CAP_W-1:0]   m_cap;
    logic [THR_W-1:0]   m_thresh;
    logic [FSEL_W-1:0]  m_fsel;
    logic [SPEED_W-1:0] m_speed;
    logic               m_init;
    logic [NOW_W-1:0]   m_last;
    logic [63:0]        m_acc;
    logic [NOW_W-1:0]   m_dropped;

    t_tick_report pending_reports[$];
    logic [NOW_W-1:0] last_stamp = '0;
    bit          sender_quiet = 1'b0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned reports_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned n_restart = 0;
    int unsigned n_suspend = 0;
    int unsigned n_stepped = 0;
    int unsigned cycles = 0;

    fixed_step_tick_scheduler_core #(
        .HALF_FRAME_UNITS(HALF_FRAME)
    ) dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_reports.size());
            $display("fixed_step_tick_scheduler_core_tb: errors");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] step_length();
        logic [63:0] p;
        if (m_fsel == '0) p = HALF_FRAME;
        else p = m_fsel * 2 * HALF_FRAME;
        return p;
    endfunction

    task automatic reset_schedule_state();
        m_cap = RST_MAX_CATCH_UP;
        m_thresh = RST_SUSPEND_THR;
        m_fsel = RST_FRAME_RATE;
        m_speed = RST_SPEED_FACTOR;
        m_init = 1'b0;
        m_last = '0;
        m_acc = '0;
        m_dropped = '0;
    endtask

    function automatic t_tick_report predict_schedule(input logic [NOW_W-1:0] t);
        logic [63:0] period, speed, cap, delta, total, avail, ticks, frac;
        t_tick_report r;
        period = step_length();
        speed = 64'(m_speed);
        if (speed < 64'(SPEED_MIN)) speed = 64'(SPEED_MIN);
        if (speed > 64'(SPEED_MAX)) speed = 64'(SPEED_MAX);
        cap = (m_cap == '0) ? 64'd1 : 64'(m_cap);
        r.period = period[STEP_W-1:0];
        r.ticks = '0;
        r.alpha = '0;
        r.deadline = t + (period * 256) / speed;
        if (!m_init || t < m_last) begin
            m_init = 1'b1;
            m_last = t;
            m_acc = '0;
            n_restart++;
        end else begin
            delta = t - m_last;
            m_last = t;
            if (delta >= 64'(m_thresh)) begin
                m_acc = '0;
                n_suspend++;
            end else begin
                total = m_acc + ((delta * speed) >> SPEED_SH);
                avail = total / period;
                ticks = (avail < cap) ? avail : cap;
                m_dropped += avail - ticks;
                m_acc = total % period;
                frac = (m_acc << 16) / period;
                r.ticks = ticks[TICKS_W-1:0];
                r.alpha = frac[ALPHA_W-1:0];
                r.deadline = t + ((period - m_acc) * 256) / speed;
                n_stepped++;
            end
        end
        r.dropped = m_dropped;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     reports_checked, what, got, want);
    endtask

    always @(posedge i_clk) begin : check_reports
        t_tick_report want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("unexpected item", o_ticks, '0);
            end else begin
                want = pending_reports.pop_front();
                if (o_ticks !== want.ticks)
                    flag_mismatch("ticks", o_ticks, want.ticks);
                if (o_step_period !== want.period)
                    flag_mismatch("step_period", o_step_period, want.period);
                if (o_alpha !== want.alpha)
                    flag_mismatch("alpha", o_alpha, want.alpha);
                if (o_next_deadline !== want.deadline)
                    flag_mismatch("next_deadline", o_next_deadline, want.deadline);
                if (o_discarded_total !== want.dropped)
                    flag_mismatch("discarded_total", o_discarded_total, want.dropped);
            end
            reports_checked++;
        end
    end

    initial begin : drive_out_stall
        int unsigned hold;
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            if (hold == 0) begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 14) == 0) repeat (300) @(posedge i_clk);
                else repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    task automatic send_stamp(input logic [NOW_W-1:0] t);
        int unsigned gap;
        gap = sender_quiet ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now <= t;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_reports.push_back(predict_schedule(t));
        items_sent++;
        last_stamp = t;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_MAX_CATCH_UP: begin m_cap = val[CAP_W-1:0]; m_init = 1'b0; end
            CFG_SUSPEND_THR:  begin m_thresh = val[THR_W-1:0]; m_init = 1'b0; end
            CFG_FRAME_RATE:   begin m_fsel = val[FSEL_W-1:0]; m_init = 1'b0; end
            CFG_SPEED_FACTOR: begin m_speed = val[SPEED_W-1:0]; m_init = 1'b0; end
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_defaults();
        send_stamp(64'd0);
        send_stamp(64'hFFFF_FFFF_FFFF_FFFF);
        send_stamp(64'd5);
        send_stamp(64'd5);
        drain();
    endtask

    task automatic test_catch_up();
        logic [NOW_W-1:0] t;
        write_reg(CFG_MAX_CATCH_UP, 32'hFFFF_FFFF);
        write_reg(CFG_SUSPEND_THR, 32'hFFFF_FFFF);
        t = 64'h0000_0001_0000_0000;
        send_stamp(t);
        t += 300 * 131072 + 1234;
        send_stamp(t);
        t += 65536;
        send_stamp(t);
        t += 3 * 131072;
        send_stamp(t);
        t += 64'hFFFF_FFFE;
        send_stamp(t);
        drain();
        write_reg(CFG_SUSPEND_THR, 32'd1000);
        send_stamp(t);
        send_stamp(t + 999);
        send_stamp(t + 1999);
        drain();
        write_reg(CFG_MAX_CATCH_UP, 32'hFFFF_FF00);
        write_reg(CFG_SUSPEND_THR, 32'hFFFF_FFFF);
        send_stamp(t);
        send_stamp(t + 5 * 131072);
        drain();
    endtask

    task automatic test_rates_and_speed();
        logic [NOW_W-1:0] t;
        write_reg(CFG_MAX_CATCH_UP, 32'd255);
        write_reg(CFG_FRAME_RATE, 32'd0);
        write_reg(CFG_SPEED_FACTOR, 32'd0);
        t = 64'd1000;
        send_stamp(t);
        t += 2 * 65536 + 7;
        send_stamp(t);
        drain();
        write_reg(CFG_FRAME_RATE, 32'hFFFF_FFFF);
        write_reg(CFG_SPEED_FACTOR, 32'd1023);
        send_stamp(t);
        t += 1966080;
        send_stamp(t);
        drain();
        write_reg(CFG_SPEED_FACTOR, 32'd513);
        send_stamp(t);
        drain();
        write_reg(CFG_SPEED_FACTOR, 32'd255);
        send_stamp(t);
        t += 700000;
        send_stamp(t);
        drain();
        // Writes to unused indexes must leave the timing state running.
        write_reg(CFG_LAST_UNUSED, 32'hFFFF_FFFF);
        t += 1500000;
        send_stamp(t);
        drain();
        write_reg(CFG_FIRST_UNUSED, 32'd0);
        t += 2500000;
        send_stamp(t);
        drain();
    endtask

    task automatic random_setup(output bit state_kept);
        logic [CFG_DATA_W-1:0] v;
        int unsigned r;
        state_kept = 1'b0;
        if ($urandom_range(0, 4) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                      $urandom);
            state_kept = 1'b1;
            return;
        end
        if ($urandom_range(0, 3) != 0) begin
            v = $urandom;
            r = $urandom_range(0, 5);
            if (r == 0) v[7:0] = 8'd0;
            else if (r == 1) v[7:0] = 8'd1;
            else if (r == 2) v[7:0] = 8'd255;
            write_reg(CFG_MAX_CATCH_UP, v);
        end
        if ($urandom_range(0, 3) != 0) begin
            r = $urandom_range(0, 9);
            if (r < 4) v = 32'hFFFF_FFFF;
            else if (r < 7) v = $urandom | 32'h8000_0000;
            else if (r < 9) v = $urandom;
            else v = $urandom_range(0, 3);
            write_reg(CFG_SUSPEND_THR, v);
        end
        if ($urandom_range(0, 3) != 0) begin
            v = $urandom;
            r = $urandom_range(0, 4);
            if (r == 0) v[3:0] = 4'd0;
            else if (r == 1) v[3:0] = 4'd15;
            write_reg(CFG_FRAME_RATE, v);
        end
        if ($urandom_range(0, 3) != 0) begin
            v = $urandom;
            r = $urandom_range(0, 5);
            if (r == 0) v[9:0] = SPEED_MIN;
            else if (r == 1) v[9:0] = SPEED_MAX;
            else if (r < 4) v[9:0] = SPEED_W'($urandom_range(256, 512));
            write_reg(CFG_SPEED_FACTOR, v);
        end
    endtask

    function automatic logic [NOW_W-1:0] next_stamp();
        logic [63:0] period, d;
        int unsigned pick;
        period = step_length();
        pick = $urandom_range(0, 99);
        if (pick < 3) return {$urandom, $urandom};
        if (pick < 6) return last_stamp - $urandom_range(1, 5000);
        if (pick < 9) return last_stamp + m_thresh + $urandom_range(0, 2);
        case ($urandom_range(0, 3))
            0: d = $urandom_range(0, 32'(period - 64'd1));
            1: d = period * $urandom_range(1, 6) + $urandom_range(0, 15) - 8;
            2: d = $urandom_range(0, 32'(period * (m_cap + 8)));
            default: d = $urandom_range(0, 400);
        endcase
        if (m_thresh != '0 && d >= 64'(m_thresh)) d = d % m_thresh;
        return last_stamp + d;
    endfunction

    task automatic test_random();
        int unsigned left, n;
        bit kept;
        left = RANDOM_ITEMS;
        while (left > 0) begin
            drain();
            random_setup(kept);
            if (!kept) begin
                if ($urandom_range(0, 5) == 0)
                    last_stamp = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 1 << 24);
                else
                    last_stamp = {$urandom, $urandom};
            end
            sender_quiet = ($urandom_range(0, 3) == 0);
            n = $urandom_range(40, 120);
            if (n > left) n = left;
            repeat (n) send_stamp(next_stamp());
            left -= n;
        end
        sender_quiet = 1'b0;
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_schedule_state();
        test_defaults();
        test_catch_up();
        test_rates_and_speed();
        test_random();
        repeat (END_WAIT) @(posedge i_clk);
        $display("covered %0d timestamps: %0d restarts, %0d suspends, %0d stepped",
                 items_sent, n_restart, n_suspend, n_stepped);
        $display("%0d results compared, %0d register writes, %0d ticks dropped by cap",
                 reports_checked, reg_writes, m_dropped);
        if (mismatches == 0) begin
            $display("fixed_step_tick_scheduler_core_tb: clean");
        end else begin
            $display("fixed_step_tick_scheduler_core_tb: errors");
        end
        $finish;
    end

endmodule
